FILE: rtl/lade_pkg.sv
// Shared types and constants for the linear attack/decay envelope.
package lade_pkg;

    localparam int LENGTH_BITS_DEF    = 24;
    localparam int GAIN_FRAC_BITS_DEF = 16;

    localparam int SAMPLE_W = 16;
    localparam int CFG_W    = 24;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ATTACK = 2'd0,
        CFG_DECAY  = 2'd1,
        CFG_CLIP   = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV,
        ST_MUL,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load_in;
        logic setup;
        logic div_step;
        logic mul;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic need_div;
        logic out_busy;
    } status_t;

endpackage

FILE: rtl/lade_ctrl.sv
// Sequencer for the envelope: accept, region select, divide, multiply, output.
module lade_ctrl #(
    parameter int GAIN_FRAC_BITS = lade_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  lade_pkg::status_t status,
    output lade_pkg::cmd_t    cmd
);
    import lade_pkg::*;

    localparam int CNT_W = $clog2(GAIN_FRAC_BITS + 1);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_SETUP;
                end
            end
            ST_SETUP: begin
                cmd.setup  = 1'b1;
                cnt_next   = '0;
                state_next = status.need_div ? ST_DIV : ST_MUL;
            end
            ST_DIV: begin
                // one quotient bit per cycle, MSB first
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(GAIN_FRAC_BITS)) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // hold until the output register frees up
                if (!status.out_busy) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cmd))
        else $error("more than one datapath command at once");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> !status.out_busy)
        else $error("output register loaded while a beat is pending");

    a_div_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.div_step && cnt_reg == CNT_W'(GAIN_FRAC_BITS)) |=> cmd.mul)
        else $error("multiply does not follow the last divide step");
`endif

endmodule

FILE: rtl/lade_dp.sv
// Datapath: config registers, position counter, serial divider, multiplier, output register.
module lade_dp #(
    parameter int LENGTH_BITS    = lade_pkg::LENGTH_BITS_DEF,
    parameter int GAIN_FRAC_BITS = lade_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [lade_pkg::CFG_IDX_W-1:0]       cfg_idx,
    input  logic [lade_pkg::CFG_W-1:0]           cfg_wdata,
    input  logic [lade_pkg::SAMPLE_W-1:0]        s_tdata,
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [lade_pkg::SAMPLE_W-1:0]        m_tdata,
    output logic                                 m_tlast,
    input  lade_pkg::cmd_t                       cmd,
    output lade_pkg::status_t                    status
);
    import lade_pkg::*;

    localparam int L = LENGTH_BITS;
    localparam int F = GAIN_FRAC_BITS;
    localparam int G = F + 1;
    localparam int P = SAMPLE_W + G + 1;
    localparam logic [G-1:0] GAIN_ONE = {1'b1, {F{1'b0}}};
    localparam logic [L-1:0] POS_MAX  = {L{1'b1}};

    logic [L-1:0] attack_reg, decay_reg, clip_reg;
    logic [L-1:0] pos_reg, pos_next;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic         last_reg;
    logic [L:0]   rem_reg, rem_next;
    logic [L-1:0] dvs_reg, dvs_next;
    logic [G-1:0] quo_reg, quo_next;
    logic signed [P-1:0] prod_reg;
    logic [SAMPLE_W-1:0] out_data_reg;
    logic         out_last_reg;
    logic         out_valid_reg, out_valid_next;

    // region decode
    logic         past_clip, in_attack, in_decay, decay_zero;
    logic [L:0]   pos_plus_decay;
    logic         need_div;
    logic [G-1:0] const_gain;
    logic [L-1:0] div_num, div_den;

    // divide step
    logic         ge;
    logic [L:0]   diff, r_new;

    always_comb begin
        pos_plus_decay = {1'b0, pos_reg} + {1'b0, decay_reg};
        past_clip  = pos_reg > clip_reg;
        in_attack  = pos_reg < attack_reg;
        in_decay   = pos_plus_decay >= {1'b0, clip_reg};
        decay_zero = (pos_reg >= clip_reg) || (decay_reg == '0);
        need_div   = 1'b0;
        const_gain = GAIN_ONE;
        div_num    = pos_reg;
        div_den    = attack_reg;
        if (past_clip) begin
            const_gain = '0;
        end else if (in_attack) begin
            need_div = 1'b1;
        end else if (in_decay) begin
            if (decay_zero) begin
                const_gain = '0;
            end else begin
                need_div = 1'b1;
                div_num  = clip_reg - pos_reg;
                div_den  = decay_reg;
            end
        end
    end

    assign status.need_div = need_div;
    assign status.out_busy = out_valid_reg && !m_tready;

    // restoring divide: numerator never exceeds divisor, so G steps cover the quotient
    always_comb begin
        diff  = rem_reg - {1'b0, dvs_reg};
        ge    = rem_reg >= {1'b0, dvs_reg};
        r_new = ge ? diff : rem_reg;
    end

    always_comb begin
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        quo_next = quo_reg;
        if (cmd.setup) begin
            rem_next = {1'b0, div_num};
            dvs_next = div_den;
            quo_next = need_div ? '0 : const_gain;
        end else if (cmd.div_step) begin
            rem_next = {r_new[L-1:0], 1'b0};
            quo_next = {quo_reg[G-2:0], ge};
        end
    end

    always_comb begin
        pos_next = pos_reg;
        if (cmd.load_out) begin
            if (last_reg) begin
                pos_next = '0;
            end else if (pos_reg != POS_MAX) begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attack_reg    <= '0;
            decay_reg     <= '0;
            clip_reg      <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                unique case (cfg_idx)
                    CFG_ATTACK: attack_reg <= L'(cfg_wdata);
                    CFG_DECAY:  decay_reg  <= L'(cfg_wdata);
                    CFG_CLIP:   clip_reg   <= L'(cfg_wdata);
                    default: ;
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
        if (cmd.load_in) begin
            sample_reg <= s_tdata;
            last_reg   <= s_tlast;
        end
        if (cmd.mul) begin
            prod_reg <= P'(sample_reg) * P'($signed({1'b0, quo_reg}));
        end
        if (cmd.load_out) begin
            // floor shift of the Q16 product
            out_data_reg <= prod_reg[F+SAMPLE_W-1:F];
            out_last_reg <= last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

`ifndef ASSERT_OFF
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> (rem_reg < {dvs_reg, 1'b0}))
        else $error("divider remainder out of range");

    a_gain_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mul |-> (quo_reg <= GAIN_ONE))
        else $error("gain above unity");

    a_pos_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_out && last_reg) |=> (pos_reg == '0))
        else $error("position not cleared after last beat");
`endif

endmodule

FILE: rtl/linear_attack_decay_envelope.sv
// Top level of the linear attack/decay envelope: sequencer plus datapath.
//
//  port group  | dir | content
//  s_*         | in  | tdata[15:0] sample_in, tlast last_in
//  m_*         | out | tdata[15:0] sample_out, tlast last_out
//  cfg_*       | in  | write: 0 attack_samples, 1 decay_samples, 2 clip_samples
//
// One beat at a time: accept, region select, divide (ramps only), multiply, output load;
// the output load waits while the previous result is still pending.
// The restoring divider produces one quotient bit per cycle.
// The next beat is taken while the previous result waits in the output register.
// aresetn is synchronous: config registers read 0, position 0, no result pending.
module linear_attack_decay_envelope #(
    parameter int LENGTH_BITS    = lade_pkg::LENGTH_BITS_DEF,
    parameter int GAIN_FRAC_BITS = lade_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [lade_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [lade_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [lade_pkg::SAMPLE_W-1:0]  s_tdata,  // [15:0] sample_in
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [lade_pkg::SAMPLE_W-1:0]  m_tdata,  // [15:0] sample_out
    output logic                           m_tlast
);
    import lade_pkg::*;

    cmd_t    cmd;
    status_t status;

    lade_ctrl #(
        .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .status  (status),
        .cmd     (cmd)
    );

    lade_dp #(
        .LENGTH_BITS   (LENGTH_BITS),
        .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_wdata(cfg_wdata),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

FILE: tb/tb_linear_attack_decay_envelope.sv
// Self-checking testbench for the linear attack/decay envelope stream block.
`timescale 1ns / 100ps

module tb_linear_attack_decay_envelope;
    import lade_pkg::*;

    localparam int  GAIN_FRAC   = GAIN_FRAC_BITS_DEF;
    localparam int  ITEM_TARGET = 1400;
    localparam int  SETTLE_CYC  = 40;
    localparam real LIMIT_NS    = 2_000_000.0;

    // index 3 is not mapped to any register
    localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;

    localparam logic [GAIN_FRAC:0]   GAIN_ONE = {1'b1, {GAIN_FRAC{1'b0}}};
    localparam logic [CFG_W-1:0]     POS_MAX  = '1;

    typedef struct {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
    } audio_beat_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [SAMPLE_W-1:0]   s_tdata   = '0;  // [15:0] sample_in
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [SAMPLE_W-1:0]   m_tdata;         // [15:0] sample_out
    logic                  m_tlast;

    // envelope state seen by the predictor
    logic [CFG_W-1:0] attack_len = '0;
    logic [CFG_W-1:0] decay_len  = '0;
    logic [CFG_W-1:0] clip_len   = '0;
    logic [CFG_W-1:0] play_pos   = '0;

    audio_beat_t sample_feed_q[$];
    audio_beat_t enveloped_q[$];

    int mismatch_count = 0;
    int fed_count      = 0;

    linear_attack_decay_envelope DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #(LIMIT_NS);
        $display("tb_linear_attack_decay_envelope: FAIL");
        $finish;
    end

    function automatic logic [GAIN_FRAC:0] envelope_gain(logic [CFG_W-1:0] pos);
        logic [CFG_W:0] pos_plus_decay;
        pos_plus_decay = {1'b0, pos} + {1'b0, decay_len};
        if (pos > clip_len)
            return '0;
        if (pos < attack_len)
            return (GAIN_FRAC+1)'((longint'(pos) << GAIN_FRAC) / longint'(attack_len));
        if (pos_plus_decay >= {1'b0, clip_len}) begin
            if (pos >= clip_len || decay_len == '0)
                return '0;
            return (GAIN_FRAC+1)'((longint'(clip_len - pos) << GAIN_FRAC)
                                  / longint'(decay_len));
        end
        return GAIN_ONE;
    endfunction

    // scale one accepted beat and advance the clip position
    task automatic apply_envelope(input logic [SAMPLE_W-1:0] sample, input logic last);
        logic [GAIN_FRAC:0] gain;
        longint             prod;
        audio_beat_t        res;
        gain = envelope_gain(play_pos);
        prod = longint'($signed(sample)) * longint'(gain);
        res.sample = SAMPLE_W'(prod >>> GAIN_FRAC);
        res.last   = last;
        enveloped_q.push_back(res);
        if (last)
            play_pos = '0;
        else if (play_pos != POS_MAX)
            play_pos = play_pos + 1'b1;
    endtask

    // sender: bursts of beats with random gaps in between
    int          burst_left = 0;
    int          gap_left   = 0;
    logic        next_valid;
    audio_beat_t next_beat;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            next_valid = s_tvalid;
            if (s_tvalid && s_tready) begin
                apply_envelope(s_tdata, s_tlast);
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (sample_feed_q.size() > 0) begin
                    next_beat = sample_feed_q.pop_front();
                    s_tdata   <= next_beat.sample;
                    s_tlast   <= next_beat.last;
                    next_valid = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 30);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
            s_tvalid <= next_valid;
        end
    end

    // receiver: stall pattern switches between modes every so often
    int          stall_mode = 0;
    int          mode_left  = 0;
    logic        next_ready;
    audio_beat_t want;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (enveloped_q.size() == 0) begin
                if (mismatch_count < 10)
                    $display("%0t: unexpected beat sample_out=%h last_out=%b",
                             $realtime, m_tdata, m_tlast);
                mismatch_count++;
            end else begin
                want = enveloped_q.pop_front();
                if (m_tdata !== want.sample || m_tlast !== want.last) begin
                    if (mismatch_count < 10)
                        $display("%0t: mismatch sample_out exp %h got %h, last_out exp %b got %b",
                                 $realtime, want.sample, m_tdata, want.last, m_tlast);
                    mismatch_count++;
                end
            end
        end
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 200);
        end else begin
            mode_left--;
        end
        case (stall_mode)
            0:       next_ready = 1'b1;
            1:       next_ready = 1'($urandom_range(0, 1));
            2:       next_ready = ($urandom_range(0, 3) == 0);
            default: next_ready = (mode_left % 16) < 10;
        endcase
        m_tready <= next_ready;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_ATTACK: attack_len = val;
            CFG_DECAY:  decay_len  = val;
            CFG_CLIP:   clip_len   = val;
            default:    ;
        endcase
    endtask

    // hold until every beat is accepted and every result is back; sample away from the
    // active edge so the handshake state has settled
    task automatic wait_drained();
        @(negedge aclk);
        while (sample_feed_q.size() != 0 || s_tvalid || enveloped_q.size() != 0)
            @(negedge aclk);
    endtask

    task automatic configure(input logic [CFG_W-1:0] a, input logic [CFG_W-1:0] d,
                             input logic [CFG_W-1:0] c);
        wait_drained();
        write_reg(CFG_ATTACK, a);
        write_reg(CFG_DECAY, d);
        write_reg(CFG_CLIP, c);
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_NONE, CFG_W'($urandom));
    endtask

    task automatic push_beat(input logic [SAMPLE_W-1:0] sample, input logic last);
        audio_beat_t b;
        b.sample = sample;
        b.last   = last;
        sample_feed_q.push_back(b);
        fed_count++;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return SAMPLE_W'($urandom_range(0, 6) - 3);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_length(int unsigned short_max);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return CFG_W'($urandom);
            default: return CFG_W'($urandom_range(0, short_max));
        endcase
    endfunction

    task automatic feed_frame(input int len);
        for (int i = 0; i < len; i++)
            push_beat(pick_sample(), i == len - 1);
    endtask

    logic [SAMPLE_W-1:0] ramp_samples[11] = '{
        16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001, 16'h7FFF, 16'h8000,
        16'h5555, 16'hAAAA, 16'h7FFF, 16'h8000, 16'h1234
    };

    initial begin
        int phase_items;
        int phase_end;
        int base_len;
        int frame_len;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // reset values: empty clip, all gains zero
        push_beat(16'h7FFF, 1'b0);
        push_beat(16'h8000, 1'b1);

        // attack, flat, decay, clip end and past it; unmapped write must not land
        wait_drained();
        write_reg(CFG_ATTACK, 24'd3);
        write_reg(CFG_DECAY, 24'd4);
        write_reg(CFG_CLIP, 24'd8);
        write_reg(CFG_NONE, 24'd1);
        for (int i = 0; i < 11; i++)
            push_beat(ramp_samples[i], i == 10);

        // attack overlaps a zero-length decay past the clip end
        configure(24'd6, 24'd0, 24'd5);
        for (int i = 0; i < 8; i++)
            push_beat(ramp_samples[i], i == 7);

        // no attack, decay longer than the clip
        configure(24'd0, 24'hFFFFFF, 24'd6);
        for (int i = 0; i < 4; i++)
            push_beat(ramp_samples[i + 4], i == 3);

        // random part; the first phases pin the extremes
        for (int ph = 0; fed_count < ITEM_TARGET; ph++) begin
            case (ph)
                0:       configure('1, '1, '1);
                1:       configure('0, '0, '1);
                2:       configure('1, 24'd3, 24'd20);
                default: configure(pick_length(16), pick_length(16), pick_length(40));
            endcase
            phase_items = $urandom_range(60, 160);
            phase_end   = fed_count + phase_items;
            while (fed_count < phase_end) begin
                base_len  = (clip_len < 60) ? int'(clip_len) + 1 : $urandom_range(1, 60);
                frame_len = base_len + $urandom_range(0, 2);
                // broken frame: ends early or at random
                if ($urandom_range(0, 4) == 0)
                    frame_len = $urandom_range(1, base_len + 3);
                feed_frame(frame_len);
            end
        end

        wait_drained();
        repeat (SETTLE_CYC) @(posedge aclk);
        if (mismatch_count == 0 && enveloped_q.size() == 0) begin
            $display("tb_linear_attack_decay_envelope: PASS");
        end else begin
            $display("tb_linear_attack_decay_envelope: FAIL");
        end
        $finish;
    end

endmodule

FILE: linear_attack_decay_envelope.f
rtl/lade_pkg.sv
rtl/lade_ctrl.sv
rtl/lade_dp.sv
rtl/linear_attack_decay_envelope.sv
tb/tb_linear_attack_decay_envelope.sv
